/* rtl/core/tro_pkg.sv */
// Shared types and constants for the terminated read with timeout block.
// No dependencies; imported by the register file, the engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tro_pkg;

    // APB register map: 64-bit registers at 8-byte spacing
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_TERM_PATTERN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TERM_LENGTH      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_INFINITE = 3'd4;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REASON_OPEN    = 2'd0,
        REASON_TERM    = 2'd1,
        REASON_LENGTH  = 2'd2,
        REASON_TIMEOUT = 2'd3
    } t_reason;

    typedef struct packed {
        logic [63:0] term_pattern;
        logic [3:0]  term_length;
        logic [15:0] max_length;
        logic [15:0] timeout_ticks;
        logic        timeout_infinite;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/core/tro_in_if.sv */
// Input channel: start / byte / tick beats with valid-ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tro_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/tro_out_if.sv */
// Result channel: passed-on bytes and end-of-read beats, valid-ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tro_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        read_done;
    logic [1:0]  end_reason;
    logic [15:0] bytes_so_far;

    modport source (output valid, output out_byte, output has_byte, output read_done,
                    output end_reason, output bytes_so_far, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input read_done,
                    input end_reason, input bytes_so_far, output ready);
endinterface

`default_nettype wire

/* rtl/core/tro_regs.sv */
// APB register file holding the read configuration.
// Depends on tro_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tro_regs
    import tro_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.term_pattern     <= '0;
            r_cfg.term_length      <= 4'd1;
            r_cfg.max_length       <= '0;
            r_cfg.timeout_ticks    <= '0;
            r_cfg.timeout_infinite <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TERM_PATTERN:     r_cfg.term_pattern     <= pwdata;
                REG_TERM_LENGTH:      r_cfg.term_length      <= pwdata[3:0];
                REG_MAX_LENGTH:       r_cfg.max_length       <= pwdata[15:0];
                REG_TIMEOUT_TICKS:    r_cfg.timeout_ticks    <= pwdata[15:0];
                REG_TIMEOUT_INFINITE: r_cfg.timeout_infinite <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TERM_PATTERN:     prdata = r_cfg.term_pattern;
            REG_TERM_LENGTH:      prdata = APB_DATA_W'(r_cfg.term_length);
            REG_MAX_LENGTH:       prdata = APB_DATA_W'(r_cfg.max_length);
            REG_TIMEOUT_TICKS:    prdata = APB_DATA_W'(r_cfg.timeout_ticks);
            REG_TIMEOUT_INFINITE: prdata = APB_DATA_W'(r_cfg.timeout_infinite);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/tro_engine.sv */
// Read state (open flag, byte history, counters), end-of-read decision and
// the result register. Depends on tro_pkg, tro_in_if and tro_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tro_engine
    import tro_pkg::*;
#(
    parameter int MAX_TERM_BYTES = 8,
    parameter int COUNT_BITS     = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    tro_in_if.sink     i_in,
    tro_out_if.source  o_out
);

    localparam int HIST_W = 8 * MAX_TERM_BYTES;
    localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // read state
    logic                  r_open, n_open;
    logic [HIST_W-1:0]     r_hist, n_hist;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [15:0]           r_ticks, n_ticks;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_has_byte;
    logic        r_done;
    t_reason     r_reason;
    logic [15:0] r_so_far;

    logic                  w_take;
    logic [HIST_W-1:0]     w_hist_new;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [15:0]           w_ticks_inc;
    logic [3:0]            w_n;
    logic [MAX_TERM_BYTES-1:0] w_eq;
    logic                  w_term_hit;
    logic                  w_len_hit;
    logic                  w_tmo_byte;
    logic                  w_tmo_tick;
    logic [CMP_W-1:0]      w_cnt_res;

    logic        w_res_valid;
    logic        w_res_has;
    logic        w_res_done;
    t_reason     w_res_reason;
    logic [15:0] w_res_cnt;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;

    assign w_hist_new  = HIST_W'({r_hist, i_in.rx_byte});
    assign w_cnt_inc   = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign w_ticks_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 16'd1;
    assign w_n = (i_cfg.term_length > 4'(MAX_TERM_BYTES)) ? 4'(MAX_TERM_BYTES)
                                                         : i_cfg.term_length;

    // per-byte compare; bytes beyond the terminator length always agree
    always_comb begin
        for (int k = 0; k < MAX_TERM_BYTES; k++) begin
            w_eq[k] = (w_hist_new[8*k +: 8] == i_cfg.term_pattern[8*k +: 8])
                   || (4'(k) >= w_n);
        end
    end

    assign w_term_hit = (w_n == 4'd0)
                     || ((w_cnt_inc >= COUNT_BITS'(w_n)) && (&w_eq));
    assign w_len_hit  = (i_cfg.max_length != 16'd0)
                     && (CMP_W'(w_cnt_inc) >= CMP_W'(i_cfg.max_length));
    assign w_tmo_byte = !i_cfg.timeout_infinite && (r_ticks >= i_cfg.timeout_ticks);
    assign w_tmo_tick = !i_cfg.timeout_infinite && (w_ticks_inc >= i_cfg.timeout_ticks);

    always_comb begin
        n_open       = r_open;
        n_hist       = r_hist;
        n_cnt        = r_cnt;
        n_ticks      = r_ticks;
        w_res_valid  = 1'b0;
        w_res_has    = 1'b0;
        w_res_done   = 1'b0;
        w_res_reason = REASON_OPEN;
        w_cnt_res    = CMP_W'(r_cnt);
        case (t_kind'(i_in.kind))
            KIND_START: begin
                n_open  = 1'b1;
                n_hist  = '0;
                n_cnt   = '0;
                n_ticks = '0;
            end
            KIND_BYTE: begin
                if (r_open) begin
                    n_hist      = w_hist_new;
                    n_cnt       = w_cnt_inc;
                    w_cnt_res   = CMP_W'(w_cnt_inc);
                    w_res_valid = 1'b1;
                    w_res_has   = 1'b1;
                    if (w_term_hit)      w_res_reason = REASON_TERM;
                    else if (w_len_hit)  w_res_reason = REASON_LENGTH;
                    else if (w_tmo_byte) w_res_reason = REASON_TIMEOUT;
                    w_res_done = (w_res_reason != REASON_OPEN);
                    if (w_res_done) n_open = 1'b0;
                end
            end
            KIND_TICK: begin
                if (r_open) begin
                    n_ticks = w_ticks_inc;
                    if (w_tmo_tick) begin
                        n_open       = 1'b0;
                        w_res_valid  = 1'b1;
                        w_res_done   = 1'b1;
                        w_res_reason = REASON_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
        w_res_cnt = (w_cnt_res > CMP_W'(16'hFFFF)) ? 16'hFFFF : w_cnt_res[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_hist      <= '0;
            r_cnt       <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_open  <= n_open;
                r_hist  <= n_hist;
                r_cnt   <= n_cnt;
                r_ticks <= n_ticks;
            end
            if (w_take) begin
                r_out_valid <= w_res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_out_byte <= w_res_has ? i_in.rx_byte : 8'd0;
            r_has_byte <= w_res_has;
            r_done     <= w_res_done;
            r_reason   <= w_res_reason;
            r_so_far   <= w_res_cnt;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.has_byte     = r_has_byte;
    assign o_out.read_done    = r_done;
    assign o_out.end_reason   = r_reason;
    assign o_out.bytes_so_far = r_so_far;

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_res_valid && w_res_done) |=> !r_open)
        else $error("read still open after its last beat");

    a_done_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_done == (r_reason != REASON_OPEN)))
        else $error("read_done disagrees with end_reason");

    a_tick_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_has_byte) |-> (r_reason == REASON_TIMEOUT && r_out_byte == 8'd0))
        else $error("byteless beat that is not a timeout");

    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !r_open && i_in.kind != KIND_START) |=> !r_out_valid)
        else $error("result produced with no read open");

endmodule

`default_nettype wire

/* rtl/core/terminated_read_with_timeout.sv */
// Top level of the terminated read with timeout block.
// Depends on tro_pkg, tro_in_if, tro_out_if, tro_regs and tro_engine.
//
// Usage:
//   i_in carries one beat per item: kind start, received byte or timer tick.
//   A start beat opens a read and clears the byte count, tick count and byte
//   history; it produces no result. While a read is open each byte beat gives
//   one result on o_out with the byte and the running count; the read closes
//   on that byte when the terminator matches, the byte limit is hit, or the
//   tick count has reached the timeout (checked in that order). A tick beat
//   advances the timer and, on timeout, gives one byteless closing result.
//   Bytes and ticks with no read open, and the unused kind code, are dropped.
//   Configuration sits on the APB port (64-bit registers, 8-byte spacing).
//   The user writes it only while the block is idle; the block does not enforce this.
// Timing:
//   A result is in the output register the cycle after its beat is taken.
//   One beat per cycle is sustained while the receiver takes results, set by the
//   single state update between the input handshake and the output register.
// Reset (synchronous, active low) closes any read, loads the register
// defaults and empties the output register. When the receiver stalls, the
// held result stays put and i_in.ready drops until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module terminated_read_with_timeout
    import tro_pkg::*;
#(
    parameter int MAX_TERM_BYTES = 8,
    parameter int COUNT_BITS     = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // beat channels
    tro_in_if.sink                     i_in,
    tro_out_if.source                  o_out
);

    t_cfg w_cfg;

    tro_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tro_engine #(
        .MAX_TERM_BYTES (MAX_TERM_BYTES),
        .COUNT_BITS     (COUNT_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* verif/tro_tb_pkg.sv */
// Scoreboard for the terminated read with timeout testbench: read-state predictor
// and result checks. Depends on tro_pkg (register indexes, kind and reason codes,
// configuration struct).
`timescale 1ns / 1ps

package tro_tb_pkg;
    import tro_pkg::*;

    localparam logic [1:0]  KIND_UNUSED    = 2'd3;
    localparam logic [15:0] COUNT_SAT      = 16'hFFFF;
    localparam int          TERM_BYTES_MAX = 8;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        read_done;
        logic [1:0]  end_reason;
        logic [15:0] bytes_so_far;
    } t_read_result;

    class term_read_scoreboard;
        t_cfg         cfg;
        bit           read_open;
        logic [63:0]  history;
        logic [15:0]  byte_count;
        logic [15:0]  ticks;
        t_read_result pending_results[$];
        int           errors;

        function new();
            cfg.term_pattern     = '0;
            cfg.term_length      = 4'd1;
            cfg.max_length       = '0;
            cfg.timeout_ticks    = '0;
            cfg.timeout_infinite = 1'b0;
            read_open            = 1'b0;
            history              = '0;
            byte_count           = '0;
            ticks                = '0;
            errors               = 0;
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_TERM_PATTERN:     cfg.term_pattern     = value;
                REG_TERM_LENGTH:      cfg.term_length      = value[3:0];
                REG_MAX_LENGTH:       cfg.max_length       = value[15:0];
                REG_TIMEOUT_TICKS:    cfg.timeout_ticks    = value[15:0];
                REG_TIMEOUT_INFINITE: cfg.timeout_infinite = value[0];
                default: ;
            endcase
        endfunction

        // terminator length in use, clamped to the history depth
        function int term_bytes();
            return (cfg.term_length > TERM_BYTES_MAX) ? TERM_BYTES_MAX : int'(cfg.term_length);
        endfunction

        function bit terminator_matched();
            int          n;
            logic [63:0] mask;
            n = term_bytes();
            if (n == 0) return 1'b1;
            if (byte_count < n) return 1'b0;
            mask = (n == TERM_BYTES_MAX) ? '1 : (64'd1 << (8 * n)) - 64'd1;
            return (history & mask) == (cfg.term_pattern & mask);
        endfunction

        // append an expected result at the tail of the queue
        function void queue_result(t_read_result r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        // advance the read state by one accepted beat, queueing any result it causes
        function void take_beat(logic [1:0] kind, logic [7:0] rx_byte);
            t_read_result r;
            r = '0;
            if (kind == KIND_START) begin
                read_open  = 1'b1;
                history    = '0;
                byte_count = '0;
                ticks      = '0;
                return;
            end
            if (!read_open) return;
            if (kind == KIND_BYTE) begin
                if (byte_count != COUNT_SAT) byte_count++;
                history = {history[55:0], rx_byte};
                if (terminator_matched())
                    r.end_reason = REASON_TERM;
                else if (cfg.max_length != 0 && byte_count >= cfg.max_length)
                    r.end_reason = REASON_LENGTH;
                else if (!cfg.timeout_infinite && ticks >= cfg.timeout_ticks)
                    r.end_reason = REASON_TIMEOUT;
                r.out_byte     = rx_byte;
                r.has_byte     = 1'b1;
                r.read_done    = (r.end_reason != REASON_OPEN);
                r.bytes_so_far = byte_count;
                if (r.read_done) read_open = 1'b0;
                queue_result(r);
            end else if (kind == KIND_TICK) begin
                if (ticks != TICK_MAX) ticks++;
                if (!cfg.timeout_infinite && ticks >= cfg.timeout_ticks) begin
                    read_open      = 1'b0;
                    r.read_done    = 1'b1;
                    r.end_reason   = REASON_TIMEOUT;
                    r.bytes_so_far = byte_count;
                    queue_result(r);
                end
            end
        endfunction

        function void field_check(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_read_result got);
            t_read_result want;
            if (pending_results.size() == 0) begin
                $error("result with none expected: out_byte %0h, bytes_so_far %0d",
                       got.out_byte, got.bytes_so_far);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            field_check("out_byte",     16'(want.out_byte),   16'(got.out_byte));
            field_check("has_byte",     16'(want.has_byte),   16'(got.has_byte));
            field_check("read_done",    16'(want.read_done),  16'(got.read_done));
            field_check("end_reason",   16'(want.end_reason), 16'(got.end_reason));
            field_check("bytes_so_far", want.bytes_so_far,    got.bytes_so_far);
        endfunction
    endclass

endpackage

/* verif/terminated_read_with_timeout_tb.sv */
// Testbench top for terminated_read_with_timeout: drives start, byte and tick beats and
// APB writes, checks every result beat against the scoreboard. Depends on tro_pkg,
// tro_in_if, tro_out_if, tro_tb_pkg and the block itself.
`timescale 1ns / 1ps

module terminated_read_with_timeout_tb;
    import tro_pkg::*;
    import tro_tb_pkg::*;

    localparam int CLEAR_CYCLES = 4;      // covers a beat still in flight, with a little margin
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PHASE_BEATS  = 175;    // eight phases, about 1400 beats in reads

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tro_in_if  in_ch ();
    tro_out_if out_ch ();

    int send_idle_pct;
    int recv_stall_pct;

    term_read_scoreboard sb;

    terminated_read_with_timeout dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result side: ready is redrawn at every falling edge, beats are taken at the
    // rising edge. A stall percentage of zero keeps ready high throughout.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : take_result
        t_read_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.out_byte     = out_ch.out_byte;
            got.has_byte     = out_ch.has_byte;
            got.read_done    = out_ch.read_done;
            got.end_reason   = out_ch.end_reason;
            got.bytes_so_far = out_ch.bytes_so_far;
            sb.check_result(got);
        end
    end

    // One input beat. Idle cycles are drawn first; valid then stays up until the
    // beat is taken, and the scoreboard sees it at that same rising edge.
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] rx_byte);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.rx_byte <= rx_byte;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.take_beat(kind, rx_byte);
    endtask

    // Hold the input quiet until every queued result is out, then allow for a
    // beat still in flight that gives no result (start, dropped byte, plain tick).
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && sb.pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (CLEAR_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, then access; the register takes the value at the access edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [63:0] pattern, input logic [3:0] term_len,
                             input logic [15:0] max_len, input logic [15:0] tmo,
                             input logic infinite);
        settle();
        write_reg(REG_TERM_PATTERN, pattern);
        write_reg(REG_TERM_LENGTH, 64'(term_len));
        write_reg(REG_MAX_LENGTH, 64'(max_len));
        write_reg(REG_TIMEOUT_TICKS, 64'(tmo));
        write_reg(REG_TIMEOUT_INFINITE, 64'(infinite));
    endtask

    // Mostly short limits and timeouts so reads close often; now and then the
    // wide values, an empty terminator, or a length beyond the history depth.
    task automatic random_config();
        logic [3:0]  term_len;
        logic [15:0] max_len;
        logic [15:0] tmo;
        term_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        max_len  = ($urandom_range(0, 9) < 3) ? 16'd0 : 16'($urandom_range(1, 24));
        case ($urandom_range(0, 19))
            0, 1, 2: tmo = 16'd0;
            3, 4:    tmo = 16'($urandom_range(1000, 65535));
            default: tmo = 16'($urandom_range(1, 12));
        endcase
        configure({$urandom, $urandom}, term_len, max_len, tmo, ($urandom_range(0, 4) == 0));
    endtask

    // A start followed by a random mix of ticks and bytes. Bytes are drawn from the
    // terminator often enough that partial and whole matches turn up regularly.
    task automatic run_read(output int beats);
        int steps;
        send_beat(KIND_START, 8'($urandom));
        beats = 1;
        steps = $urandom_range(1, 40);
        while (steps > 0 && sb.read_open) begin
            if ($urandom_range(0, 99) < 25) begin
                send_beat(KIND_TICK, 8'($urandom));
                beats++;
            end else if ($urandom_range(0, 99) < 20) begin
                // whole terminator, oldest byte first
                for (int i = sb.term_bytes() - 1; i >= 0 && sb.read_open; i--) begin
                    send_beat(KIND_BYTE, sb.cfg.term_pattern[8*i +: 8]);
                    beats++;
                end
            end else if ($urandom_range(0, 99) < 35) begin
                send_beat(KIND_BYTE, sb.cfg.term_pattern[8*$urandom_range(0, 7) +: 8]);
                beats++;
            end else begin
                send_beat(KIND_BYTE, 8'($urandom));
                beats++;
            end
            steps--;
        end
    endtask

    // Stray beats of any kind, the unused code included; mostly land with no read open.
    task automatic send_noise();
        repeat ($urandom_range(1, 4)) send_beat(2'($urandom), 8'($urandom));
    endtask

    initial begin
        int beats;
        int n;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_START;
        in_ch.rx_byte = 8'h00;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb = new();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: CR LF terminator, three-tick timeout ----
        configure(64'h0D0A, 4'd2, 16'd0, 16'd3, 1'b0);
        send_beat(KIND_BYTE, 8'h41);     // no read open: dropped
        send_beat(KIND_TICK, 8'h00);     // no read open: nothing
        send_beat(KIND_UNUSED, 8'hFF);   // unused kind: ignored
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_BYTE, 8'hFF);
        send_beat(KIND_BYTE, 8'h0D);
        send_beat(KIND_BYTE, 8'h0A);     // terminator closes the read
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_TICK, 8'h00);
        send_beat(KIND_TICK, 8'h00);
        send_beat(KIND_BYTE, 8'h55);     // two ticks of three: still open
        send_beat(KIND_TICK, 8'h00);     // timeout on a tick: byteless closing beat
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_START, 8'h00);    // restart over an open read
        send_beat(KIND_BYTE, 8'h0D);

        // terminator and length limit on the same byte: terminator wins
        configure(64'h0D0A, 4'd2, 16'd2, 16'd3, 1'b1);
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_BYTE, 8'h0D);
        send_beat(KIND_BYTE, 8'h0A);

        // empty terminator: first byte ends the read
        configure(64'h0D0A, 4'd0, 16'd2, 16'd3, 1'b1);
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_BYTE, 8'hAA);

        // zero timeout, eight-byte terminator not yet reachable
        configure('1, 4'd8, 16'd0, 16'd0, 1'b0);
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_BYTE, 8'hFF);     // non-blocking: first byte times out
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_TICK, 8'h00);     // ... or the first tick, count zero

        // ---- random phases: extremes first, then random settings ----
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       configure(64'h0, 4'd0, 16'd0, 16'd5, 1'b0);
                1:       configure('1, 4'd8, 16'hFFFF, 16'hFFFF, 1'b0);
                2:       configure({$urandom, $urandom}, 4'd3, 16'd1, 16'd0, 1'b0);
                3:       configure({$urandom, $urandom}, 4'd15, 16'd0, 16'd0, 1'b1);
                default: random_config();
            endcase
            // idling pattern rotates: none, sender gaps, receiver stalls, light on both
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            beats = 0;
            while (beats < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_noise();
                end else begin
                    run_read(n);
                    beats += n;
                end
                // occasionally hold off until the result side has fully drained
                if ($urandom_range(0, 99) < 3) settle();
            end
        end

        settle();
        if (sb.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("terminated_read_with_timeout_tb: clean");
        else
            $display("terminated_read_with_timeout_tb: errors");
        $finish;
    end

    // hard stop well past the slowest legitimate run
    initial begin
        #20_000_000;
        $display("terminated_read_with_timeout_tb: errors");
        $finish;
    end

endmodule
